// ===== sv/nal_pkg.sv =====
// shared types and constants for the numa-aware queue lock arbiter
// no dependencies; imported by the request and result interfaces and the arbiter
package nal_pkg;

  localparam int REQUESTERS = 16;
  localparam int SOCKETS    = 4;
  localparam int ID_W       = $clog2(REQUESTERS);
  localparam int SK_W       = $clog2(SOCKETS);

  typedef logic [ID_W-1:0] id_t;
  typedef logic [SK_W-1:0] sk_t;

  localparam logic OP_ACQUIRE = 1'b0;
  localparam logic OP_RELEASE = 1'b1;

  typedef struct packed {
    logic link_we;
    id_t  link_waddr;
    id_t  link_wdata;
    logic sock_we;
    id_t  sock_waddr;
    sk_t  sock_wdata;
  } store_wr_t;

  typedef struct packed {
    id_t link_raddr;
    id_t sock_raddr;
  } store_rd_t;

endpackage

// ===== sv/nal_req_if.sv =====
// request channel: operation, requester id and socket with valid/ready
// depends on nal_pkg
interface nal_req_if import nal_pkg::*; ();
  logic valid;
  logic ready;
  logic operation;
  id_t  requester_id;
  sk_t  socket;

  modport source (output valid, operation, requester_id, socket, input ready);
  modport sink   (input valid, operation, requester_id, socket, output ready);
endinterface

// ===== sv/nal_res_if.sv =====
// result channel: grant, granted id, lock state and error with valid/ready
// depends on nal_pkg
interface nal_res_if import nal_pkg::*; ();
  logic valid;
  logic ready;
  logic granted;
  id_t  granted_id;
  logic lock_free;
  logic error;

  modport source (output valid, granted, granted_id, lock_free, error, input ready);
  modport sink   (input valid, granted, granted_id, lock_free, error, output ready);
endinterface

// ===== sv/nal_cfg_if.sv =====
// configuration write channel: keep_local_enable with valid/ready
// no dependencies
interface nal_cfg_if ();
  logic valid;
  logic ready;
  logic data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

// ===== sv/numa_aware_queue_lock_arbiter.sv =====
// numa-aware queue lock arbiter: one request at a time under a small sequencer
// acquire: result set in S_ACQ; release: S_REL, then, if keep_local_enable and waiters,
// a walk of up to REQUESTERS-1 main-queue waiters on the link/socket store for one on the
// holder's socket, else S_SEC; next request taken the cycle after the result is delivered
// rst_n (synchronous) frees the lock, empties both queues, clears busy flags,
// sets keep_local_enable; link and socket store are not cleared
module numa_aware_queue_lock_arbiter import nal_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  nal_req_if.sink   in_ch,
  nal_res_if.source out_ch,
  nal_cfg_if.sink   cfg_ch
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_ACQ  = 3'd1;
  localparam logic [2:0] S_REL  = 3'd2;
  localparam logic [2:0] S_WALK = 3'd3;
  localparam logic [2:0] S_SEC  = 3'd4;

  logic [2:0] state_r, state_nxt;
  logic keep_local_r;
  logic holder_valid_r, holder_valid_nxt;
  id_t  holder_id_r, holder_id_nxt;
  id_t  main_head_r, main_head_nxt;
  id_t  main_tail_r, main_tail_nxt;
  logic main_empty_r, main_empty_nxt;
  id_t  second_head_r, second_head_nxt;
  id_t  second_tail_r, second_tail_nxt;
  logic second_empty_r, second_empty_nxt;
  logic [REQUESTERS-1:0] busy_r, busy_nxt;

  id_t  id_r;
  sk_t  sk_r;
  sk_t  hs_r, hs_nxt;
  id_t  cur_r, cur_nxt;
  id_t  prev_r, prev_nxt;
  id_t  n_r, n_nxt;

  logic out_valid_r, out_valid_nxt;
  logic out_granted_r, out_granted_nxt;
  id_t  out_gid_r, out_gid_nxt;
  logic out_free_r, out_free_nxt;
  logic out_err_r, out_err_nxt;

  store_wr_t wr;
  store_rd_t rd;
  id_t link_rd;
  sk_t sock_rd;

  logic in_fire;

  nal_store #(
    .WIDTH (ID_W),
    .DEPTH (REQUESTERS)
  ) u_link (
    .clk   (clk),
    .we    (wr.link_we),
    .waddr (wr.link_waddr),
    .wdata (wr.link_wdata),
    .raddr (rd.link_raddr),
    .rdata (link_rd)
  );

  nal_store #(
    .WIDTH (SK_W),
    .DEPTH (REQUESTERS)
  ) u_sock (
    .clk   (clk),
    .we    (wr.sock_we),
    .waddr (wr.sock_waddr),
    .wdata (wr.sock_wdata),
    .raddr (rd.sock_raddr),
    .rdata (sock_rd)
  );

  assign in_ch.ready  = (state_r == S_IDLE) && !out_valid_r;
  assign in_fire      = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;

  assign out_ch.valid      = out_valid_r;
  assign out_ch.granted    = out_granted_r;
  assign out_ch.granted_id = out_gid_r;
  assign out_ch.lock_free  = out_free_r;
  assign out_ch.error      = out_err_r;

  always_comb begin
    state_nxt        = state_r;
    holder_valid_nxt = holder_valid_r;
    holder_id_nxt    = holder_id_r;
    main_head_nxt    = main_head_r;
    main_tail_nxt    = main_tail_r;
    main_empty_nxt   = main_empty_r;
    second_head_nxt  = second_head_r;
    second_tail_nxt  = second_tail_r;
    second_empty_nxt = second_empty_r;
    busy_nxt         = busy_r;
    hs_nxt           = hs_r;
    cur_nxt          = cur_r;
    prev_nxt         = prev_r;
    n_nxt            = n_r;
    out_valid_nxt    = out_valid_r && !out_ch.ready;
    out_granted_nxt  = out_granted_r;
    out_gid_nxt      = out_gid_r;
    out_free_nxt     = out_free_r;
    out_err_nxt      = out_err_r;
    wr               = '0;

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          state_nxt = (in_ch.operation == OP_ACQUIRE) ? S_ACQ : S_REL;
        end
      end
      S_ACQ: begin
        out_valid_nxt   = 1'b1;
        out_granted_nxt = 1'b0;
        out_gid_nxt     = '0;
        out_err_nxt     = 1'b0;
        state_nxt       = S_IDLE;
        if (busy_r[id_r]) begin
          out_err_nxt = 1'b1;
        end else begin
          busy_nxt[id_r] = 1'b1;
          wr.sock_we     = 1'b1;
          wr.sock_waddr  = id_r;
          wr.sock_wdata  = sk_r;
          if (!holder_valid_r) begin
            holder_valid_nxt = 1'b1;
            holder_id_nxt    = id_r;
            out_granted_nxt  = 1'b1;
            out_gid_nxt      = id_r;
          end else begin
            if (main_empty_r) begin
              main_head_nxt = id_r;
            end else begin
              wr.link_we    = 1'b1;
              wr.link_waddr = main_tail_r;
              wr.link_wdata = id_r;
            end
            main_tail_nxt  = id_r;
            main_empty_nxt = 1'b0;
          end
        end
        out_free_nxt = !holder_valid_nxt;
      end
      S_REL: begin
        if (!holder_valid_r || holder_id_r != id_r) begin
          out_valid_nxt   = 1'b1;
          out_granted_nxt = 1'b0;
          out_gid_nxt     = '0;
          out_err_nxt     = 1'b1;
          out_free_nxt    = !holder_valid_r;
          state_nxt       = S_IDLE;
        end else begin
          busy_nxt[id_r] = 1'b0;
          hs_nxt         = sock_rd;
          cur_nxt        = main_head_r;
          prev_nxt       = main_head_r;
          n_nxt          = '0;
          state_nxt      = (keep_local_r && !main_empty_r) ? S_WALK : S_SEC;
        end
      end
      S_WALK: begin
        if (sock_rd == hs_r) begin
          if (n_r == '0) begin
            if (main_head_r == main_tail_r) begin
              main_empty_nxt = 1'b1;
            end else begin
              main_head_nxt = link_rd;
            end
          end else begin
            if (second_empty_r) begin
              second_head_nxt = main_head_r;
            end else begin
              wr.link_we    = 1'b1;
              wr.link_waddr = second_tail_r;
              wr.link_wdata = main_head_r;
            end
            second_tail_nxt  = prev_r;
            second_empty_nxt = 1'b0;
            if (cur_r == main_tail_r) begin
              main_empty_nxt = 1'b1;
            end else begin
              main_head_nxt = link_rd;
            end
          end
          holder_id_nxt   = cur_r;
          out_valid_nxt   = 1'b1;
          out_granted_nxt = 1'b1;
          out_gid_nxt     = cur_r;
          out_free_nxt    = 1'b0;
          out_err_nxt     = 1'b0;
          state_nxt       = S_IDLE;
        end else if (cur_r == main_tail_r || n_r == ID_W'(REQUESTERS - 1)) begin
          state_nxt = S_SEC;
        end else begin
          prev_nxt = cur_r;
          cur_nxt  = link_rd;
          n_nxt    = n_r + 1'b1;
        end
      end
      S_SEC: begin
        out_valid_nxt   = 1'b1;
        out_err_nxt     = 1'b0;
        out_granted_nxt = 1'b1;
        out_free_nxt    = 1'b0;
        state_nxt       = S_IDLE;
        if (!second_empty_r) begin
          out_gid_nxt   = second_head_r;
          holder_id_nxt = second_head_r;
          if (second_head_r != second_tail_r) begin
            if (main_empty_r) begin
              main_tail_nxt = second_tail_r;
            end else begin
              wr.link_we    = 1'b1;
              wr.link_waddr = second_tail_r;
              wr.link_wdata = main_head_r;
            end
            main_head_nxt  = link_rd;
            main_empty_nxt = 1'b0;
          end
          second_empty_nxt = 1'b1;
        end else if (!main_empty_r) begin
          out_gid_nxt   = main_head_r;
          holder_id_nxt = main_head_r;
          if (main_head_r == main_tail_r) begin
            main_empty_nxt = 1'b1;
          end else begin
            main_head_nxt = link_rd;
          end
        end else begin
          holder_valid_nxt = 1'b0;
          out_granted_nxt  = 1'b0;
          out_gid_nxt      = '0;
          out_free_nxt     = 1'b1;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // store reads are registered: address the entry the next state consumes
    rd.link_raddr = cur_nxt;
    rd.sock_raddr = cur_nxt;
    if (state_r == S_IDLE) begin
      rd.sock_raddr = in_ch.requester_id;
    end
    if (state_nxt == S_SEC) begin
      rd.link_raddr = second_empty_r ? main_head_r : second_head_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_IDLE;
      keep_local_r   <= 1'b1;
      holder_valid_r <= 1'b0;
      holder_id_r    <= '0;
      main_head_r    <= '0;
      main_tail_r    <= '0;
      main_empty_r   <= 1'b1;
      second_head_r  <= '0;
      second_tail_r  <= '0;
      second_empty_r <= 1'b1;
      busy_r         <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      state_r        <= state_nxt;
      holder_valid_r <= holder_valid_nxt;
      holder_id_r    <= holder_id_nxt;
      main_head_r    <= main_head_nxt;
      main_tail_r    <= main_tail_nxt;
      main_empty_r   <= main_empty_nxt;
      second_head_r  <= second_head_nxt;
      second_tail_r  <= second_tail_nxt;
      second_empty_r <= second_empty_nxt;
      busy_r         <= busy_nxt;
      out_valid_r    <= out_valid_nxt;
      if (cfg_ch.valid && cfg_ch.ready) begin
        keep_local_r <= cfg_ch.data;
      end
    end
  end

  // request and walk registers carry no reset
  always_ff @(posedge clk) begin
    if (in_fire) begin
      id_r <= in_ch.requester_id;
      sk_r <= in_ch.socket;
    end
    hs_r          <= hs_nxt;
    cur_r         <= cur_nxt;
    prev_r        <= prev_nxt;
    n_r           <= n_nxt;
    out_granted_r <= out_granted_nxt;
    out_gid_r     <= out_gid_nxt;
    out_free_r    <= out_free_nxt;
    out_err_r     <= out_err_nxt;
  end

endmodule

// ===== sv/nal_store.sv =====
// generic ram: one write port and one read port with registered read data
// no dependencies; contents undefined until written
module nal_store #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule
